/* design/pcq_pkg.sv */
// Shared types, codes and constant tables for the pixel color quantizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pcq_pkg;

  localparam int COLOR_FRAC_BITS_DEF = 12;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_KIND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ENABLE = 2'd3;

  // pixel formats (codes above 24-bit behave as 24-bit)
  localparam logic [2:0] FMT_EGA4  = 3'd0;
  localparam logic [2:0] FMT_PAL8  = 3'd1;
  localparam logic [2:0] FMT_RGB15 = 3'd2;
  localparam logic [2:0] FMT_RGB16 = 3'd3;
  localparam logic [2:0] FMT_RGB24 = 3'd4;

  // 8-bit palette kinds
  localparam logic [1:0] PAL_GREY = 2'd0;
  localparam logic [1:0] PAL_884  = 2'd1;
  localparam logic [1:0] PAL_666  = 2'd2;
  localparam logic [1:0] PAL_EGA  = 2'd3;

  // dither shift codes: bump divided by 1, 8 or 64
  localparam logic [1:0] DSH_NONE = 2'd0;
  localparam logic [1:0] DSH_BY8  = 2'd1;
  localparam logic [1:0] DSH_BY64 = 2'd2;

  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  typedef struct packed {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic [2:0]         x_low;
    logic [2:0]         y_low;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] byte_low;
    logic [7:0] byte_mid;
    logic [7:0] byte_high;
    logic [1:0] byte_count;
  } pix_out_t;

  typedef struct packed {
    logic [2:0] pixel_format;
    logic [1:0] palette_kind;
    logic [7:0] palette_start;
    logic       dither_enable;
  } pcq_cfg_t;

  // 8x8 Bayer matrix, indexed by {x_low, y_low}
  localparam logic [5:0] BAYER [64] = '{
    6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
    6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  localparam logic [3:0] EGA_ORDER [16] = '{
    4'd0, 4'd6,  4'd5,  4'd4,  4'd3,  4'd2,  4'd1,  4'd7,
    4'd8, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9,  4'd15
  };

  // v * 255 as (v << 8) - v
  function automatic logic signed [23:0] times255(input logic signed [15:0] v);
    logic [23:0] ve;
    ve = {{8{v[15]}}, v};
    return $signed({v, 8'h00} - ve);
  endfunction

  function automatic logic [1:0] dither_shift(input logic [2:0] fmt);
    logic [1:0] sh;
    case (fmt)
      FMT_EGA4, FMT_PAL8:   sh = DSH_NONE;
      FMT_RGB15, FMT_RGB16: sh = DSH_BY8;
      default:              sh = DSH_BY64;
    endcase
    return sh;
  endfunction

  // x / 51 for a byte, result 0..5
  function automatic logic [2:0] div51(input logic [7:0] x);
    logic [2:0] q;
    q = 3'd0;
    if (x >= 8'd51)  q = 3'd1;
    if (x >= 8'd102) q = 3'd2;
    if (x >= 8'd153) q = 3'd3;
    if (x >= 8'd204) q = 3'd4;
    if (x == 8'd255) q = 3'd5;
    return q;
  endfunction

endpackage

/* design/pcq_ega.sv */
// EGA 16-color index from the three plane sums and the channel total.
// Depends on pcq_pkg (EGA remap table).
`timescale 1ns / 1ps

module pcq_ega import pcq_pkg::*; #(
  parameter int FracBits = COLOR_FRAC_BITS_DEF,
  parameter int NumW     = 32
) (
  input  logic signed [NumW-1:0] sum_rg_i,   // r + g - b
  input  logic signed [NumW-1:0] sum_rb_i,   // r - g + b
  input  logic signed [NumW-1:0] sum_gb_i,   // -r + g + b
  input  logic signed [NumW-1:0] sum_all_i,  // r + g + b
  output logic [3:0]             idx_o
);

  localparam logic signed [NumW-1:0] Half  = NumW'(255 * (2 ** (FracBits - 1)));
  localparam logic signed [NumW-1:0] Half3 = NumW'(3 * 255 * (2 ** (FracBits - 1)));
  localparam logic signed [NumW-1:0] Half5 = NumW'(5 * 255 * (2 ** (FracBits - 1)));

  logic [2:0] planes;
  logic       over1, over3, over5;
  logic [3:0] raw;

  always_comb begin
    planes = {sum_gb_i > Half, sum_rb_i > Half, sum_rg_i > Half};
    over1  = sum_all_i > Half;
    over3  = sum_all_i > Half3;
    over5  = sum_all_i > Half5;
    case (planes)
      3'b000:  raw = over1 ? 4'd7 : 4'd0;   // dark: black or grey
      3'b111:  raw = over5 ? 4'd15 : 4'd8;  // all planes: dark grey or white
      default: raw = {over3, planes};
    endcase
    idx_o = EGA_ORDER[raw];
  end

endmodule

/* design/pcq_pack.sv */
// Packs clamped channel bytes into the configured pixel format.
// Depends on pcq_pkg (format codes, palette kinds, output struct).
`timescale 1ns / 1ps

module pcq_pack import pcq_pkg::*; (
  input  pcq_cfg_t   cfg_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [3:0] ega_idx_i,
  output pix_out_t   pix_o
);

  logic [7:0] idx;
  logic [7:0] max_rg, max_rgb;
  logic [7:0] cube;

  always_comb begin
    max_rg  = (red_i > green_i) ? red_i : green_i;
    max_rgb = (blue_i > max_rg) ? blue_i : max_rg;
    cube    = 8'd36 * {5'd0, div51(red_i)} + 8'd6 * {5'd0, div51(green_i)}
              + {5'd0, div51(blue_i)};

    if (cfg_i.pixel_format == FMT_EGA4 || cfg_i.palette_kind == PAL_EGA) begin
      idx = {4'd0, ega_idx_i};
    end else begin
      case (cfg_i.palette_kind)
        PAL_666: idx = cube;
        PAL_884: idx = (red_i & 8'hE0) | ((green_i & 8'hE0) >> 3) | (blue_i >> 6);
        default: idx = max_rgb >> 2;
      endcase
    end

    pix_o = '0;
    case (cfg_i.pixel_format)
      FMT_EGA4, FMT_PAL8: begin
        pix_o.byte_low   = idx + cfg_i.palette_start;
        pix_o.byte_count = CNT_ONE;
      end
      FMT_RGB15: begin
        pix_o.byte_mid   = ((red_i >> 1) & 8'h7C) | (green_i >> 6);
        pix_o.byte_low   = ((green_i << 2) & 8'hE0) | (blue_i >> 3);
        pix_o.byte_count = CNT_TWO;
      end
      FMT_RGB16: begin
        pix_o.byte_mid   = (red_i & 8'hF8) | (green_i >> 5);
        pix_o.byte_low   = ((green_i << 3) & 8'hE0) | (blue_i >> 3);
        pix_o.byte_count = CNT_TWO;
      end
      default: begin
        pix_o.byte_high  = red_i;
        pix_o.byte_mid   = green_i;
        pix_o.byte_low   = blue_i;
        pix_o.byte_count = CNT_THREE;
      end
    endcase
  end

endmodule

/* design/pixel_color_quantizer.sv */
// Pixel color quantizer: accepts one RGB pixel per clock while in_stall_o
// is low and produces the packed pixel bytes for the configured display
// format. Its stages are times255, dither add, shift/clamp with EGA plane
// sums, EGA index, format pack into the output register. Each stage holds
// its own valid bit and advances when the stage after it is empty or
// moving, so a stalled output only backs up the input once every stage
// holds a request. Configuration is sampled per request as it enters.
// Depends on pcq_pkg, pcq_ega and pcq_pack.
`timescale 1ns / 1ps

module pixel_color_quantizer import pcq_pkg::*; #(
  parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pix_out_t              out_data_o
);

  localparam int NumW = (COLOR_FRAC_BITS + 8 > 32) ? COLOR_FRAC_BITS + 8 : 32;

  pcq_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format  <= FMT_PAL8;
      cfg_q.palette_kind  <= PAL_884;
      cfg_q.palette_start <= 8'd0;
      cfg_q.dither_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_wdata_i[2:0];
        CFG_PALETTE_KIND:  cfg_q.palette_kind  <= cfg_wdata_i[1:0];
        CFG_PALETTE_START: cfg_q.palette_start <= cfg_wdata_i;
        CFG_DITHER_ENABLE: cfg_q.dither_enable <= cfg_wdata_i[0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  // stage valids and enables, stage 5 is the output register
  logic [5:1] vld_q;
  logic [5:1] en;

  always_comb begin
    en[5] = !vld_q[5] || !out_stall_i;
    en[4] = !vld_q[4] || en[5];
    en[3] = !vld_q[3] || en[4];
    en[2] = !vld_q[2] || en[3];
    en[1] = !vld_q[1] || en[2];
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = vld_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) vld_q[1] <= in_valid_i;
      if (en[2]) vld_q[2] <= vld_q[1];
      if (en[3]) vld_q[3] <= vld_q[2];
      if (en[4]) vld_q[4] <= vld_q[3];
      if (en[5]) vld_q[5] <= vld_q[4];
    end
  end

  // ---- stage 1: channels times 255, dither value, config snapshot
  logic signed [23:0] s1_v255_q [3];
  logic [5:0]         s1_dith_q;
  logic [1:0]         s1_dsh_q;
  pcq_cfg_t           s1_cfg_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_v255_q[0] <= times255(in_data_i.red);
      s1_v255_q[1] <= times255(in_data_i.green);
      s1_v255_q[2] <= times255(in_data_i.blue);
      s1_dith_q    <= cfg_q.dither_enable ? BAYER[{in_data_i.x_low, in_data_i.y_low}]
                                          : 6'd0;
      s1_dsh_q     <= dither_shift(cfg_q.pixel_format);
      s1_cfg_q     <= cfg_q;
    end
  end

  // ---- stage 2: numerators for quantizing and EGA channel values
  logic signed [NumW-1:0] s2_num_d [3];
  logic signed [NumW-1:0] s2_ega_d [3];
  logic signed [NumW-1:0] s2_num_q [3];
  logic signed [NumW-1:0] s2_ega_q [3];
  logic [1:0]             s2_dsh_q;
  pcq_cfg_t               s2_cfg_q;
  logic [NumW-1:0]        bump;
  logic [NumW-1:0]        v_ext [3];

  always_comb begin
    bump = {{(NumW-6){1'b0}}, s1_dith_q} << COLOR_FRAC_BITS;
    for (int c = 0; c < 3; c++) begin
      v_ext[c] = {{(NumW-24){s1_v255_q[c][23]}}, s1_v255_q[c]};
      s2_ega_d[c] = $signed(v_ext[c] + bump);
      case (s1_dsh_q)
        DSH_BY8:  s2_num_d[c] = $signed((v_ext[c] << 3) + bump);
        DSH_BY64: s2_num_d[c] = $signed((v_ext[c] << 6) + bump);
        default:  s2_num_d[c] = $signed(v_ext[c] + bump);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_num_q <= s2_num_d;
      s2_ega_q <= s2_ega_d;
      s2_dsh_q <= s1_dsh_q;
      s2_cfg_q <= s1_cfg_q;
    end
  end

  // ---- stage 3: shift and clamp to bytes, EGA plane sums
  logic [NumW-1:0]        quot [3];
  logic [7:0]             s3_byte_d [3];
  logic [7:0]             s3_byte_q [3];
  logic signed [NumW-1:0] s3_rg_q, s3_rb_q, s3_gb_q, s3_all_q;
  pcq_cfg_t               s3_cfg_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (s2_dsh_q)
        DSH_BY8:  quot[c] = s2_num_q[c] >> (COLOR_FRAC_BITS + 3);
        DSH_BY64: quot[c] = s2_num_q[c] >> (COLOR_FRAC_BITS + 6);
        default:  quot[c] = s2_num_q[c] >> COLOR_FRAC_BITS;
      endcase
      if (s2_num_q[c][NumW-1] || s2_num_q[c] == '0) begin
        s3_byte_d[c] = 8'd0;
      end else if (|quot[c][NumW-1:8]) begin
        s3_byte_d[c] = 8'd255;
      end else begin
        s3_byte_d[c] = quot[c][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_byte_q <= s3_byte_d;
      s3_rg_q   <= s2_ega_q[0] + s2_ega_q[1] - s2_ega_q[2];
      s3_rb_q   <= s2_ega_q[0] - s2_ega_q[1] + s2_ega_q[2];
      s3_gb_q   <= s2_ega_q[1] + s2_ega_q[2] - s2_ega_q[0];
      s3_all_q  <= s2_ega_q[0] + s2_ega_q[1] + s2_ega_q[2];
      s3_cfg_q  <= s2_cfg_q;
    end
  end

  // ---- stage 4: EGA index
  logic [3:0] s4_ega_d, s4_ega_q;
  logic [7:0] s4_byte_q [3];
  pcq_cfg_t   s4_cfg_q;

  pcq_ega #(
    .FracBits (COLOR_FRAC_BITS),
    .NumW     (NumW)
  ) u_ega (
    .sum_rg_i  (s3_rg_q),
    .sum_rb_i  (s3_rb_q),
    .sum_gb_i  (s3_gb_q),
    .sum_all_i (s3_all_q),
    .idx_o     (s4_ega_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_ega_q  <= s4_ega_d;
      s4_byte_q <= s3_byte_q;
      s4_cfg_q  <= s3_cfg_q;
    end
  end

  // ---- stage 5: format pack into the output register
  pix_out_t pix_d;
  pix_out_t out_q;

  pcq_pack u_pack (
    .cfg_i     (s4_cfg_q),
    .red_i     (s4_byte_q[0]),
    .green_i   (s4_byte_q[1]),
    .blue_i    (s4_byte_q[2]),
    .ega_idx_i (s4_ega_q),
    .pix_o     (pix_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_q <= pix_d;
    end
  end

  assign out_data_o = out_q;

endmodule

/* design/pcq_checker.sv */
// Port-level checks for the pixel color quantizer, bound to the top level.
// Depends on pcq_pkg and pixel_color_quantizer.
`timescale 1ns / 1ps

module pcq_checker import pcq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pix_out_t out_data_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // input backs up only when the full pipe is blocked at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.byte_count != 2'd0)
    else $error("zero byte count");

  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_count == CNT_ONE
      |-> out_data_o.byte_mid == 8'd0 && out_data_o.byte_high == 8'd0)
    else $error("palette result with upper bytes set");

  a_two_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_count == CNT_TWO |-> out_data_o.byte_high == 8'd0)
    else $error("15/16-bit result with third byte set");

endmodule

bind pixel_color_quantizer pcq_checker u_pcq_checker (.*);

/* sim/pixel_quant_checker.sv */
// Checker for the pixel color quantizer: tracks register writes, predicts the
// packed bytes of every accepted pixel and compares them with the output.
// Depends on pcq_pkg for the payload types and codes.
`timescale 1ns / 1ps

module pixel_quant_checker import pcq_pkg::*; #(
  parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  pix_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  pix_out_t              out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  pcq_cfg_t regs;
  pix_out_t expected_bytes[$];
  int errors;

  // Bayer value built level by level from the 2x2 kernel (0 2 / 3 1)
  function automatic int bayer_value(input logic [2:0] x, input logic [2:0] y);
    int v;
    v = 0;
    for (int i = 0; i < 3; i++) begin
      v += (2 * int'(x[i] ^ y[i]) + int'(x[i])) << (2 * (2 - i));
    end
    return v;
  endfunction

  function automatic logic [7:0] to_byte(input longint v, input longint d, input int k);
    longint num;
    num = v * 255 * (longint'(1) << k) + d * (longint'(1) << COLOR_FRAC_BITS);
    if (num <= 0) return 8'd0;
    num = num >>> (COLOR_FRAC_BITS + k);
    return (num > 255) ? 8'd255 : num[7:0];
  endfunction

  // plane sums on channels scaled by 255, thresholds at 0.5, 1.5 and 2.5
  function automatic logic [3:0] ega_color(input longint cr, input longint cg,
                                           input longint cb);
    longint half, thr;
    logic [3:0] idx, extra;
    logic [2:0] m;
    half = longint'(255) << (COLOR_FRAC_BITS - 1);
    thr = 3 * half;
    idx = 4'd0;
    extra = 4'd8;
    if (cr + cg - cb > half) idx[0] = 1'b1;
    if (cr - cg + cb > half) idx[1] = 1'b1;
    if (-cr + cg + cb > half) idx[2] = 1'b1;
    if (idx == 4'd0) begin
      thr = half;
      extra = 4'd7;
    end else if (idx == 4'd7) begin
      thr = 5 * half;
      idx = 4'd8;
      extra = 4'd7;
    end
    if (cr + cg + cb > thr) idx = idx | extra;
    // reorder to EGA color numbers: the mixed low codes are mirrored
    m = idx[2:0];
    if (m != 3'd0 && m != 3'd7) m = 3'd7 - m;
    return {idx[3], m};
  endfunction

  function automatic pix_out_t quantize_pixel(input pix_in_t p, input pcq_cfg_t c);
    pix_out_t res;
    longint vr, vg, vb, bump;
    int d, k;
    logic [7:0] r, g, b, top, idx;
    vr = longint'($signed(p.red));
    vg = longint'($signed(p.green));
    vb = longint'($signed(p.blue));
    d = c.dither_enable ? bayer_value(p.x_low, p.y_low) : 0;
    if (c.pixel_format == FMT_RGB15 || c.pixel_format == FMT_RGB16) k = 3;
    else if (c.pixel_format >= FMT_RGB24) k = 6;
    else k = 0;
    r = to_byte(vr, d, k);
    g = to_byte(vg, d, k);
    b = to_byte(vb, d, k);
    bump = longint'(d) << COLOR_FRAC_BITS;
    res = '0;
    res.byte_count = CNT_ONE;
    if (c.pixel_format == FMT_EGA4 || c.pixel_format == FMT_PAL8) begin
      if (c.pixel_format == FMT_EGA4 || c.palette_kind == PAL_EGA) begin
        idx = {4'd0, ega_color(vr * 255 + bump, vg * 255 + bump, vb * 255 + bump)};
      end else begin
        case (c.palette_kind)
          PAL_666: idx = 8'(6 * (6 * (r / 51) + g / 51) + b / 51);
          PAL_884: idx = (r & 8'hE0) | ((g & 8'hE0) >> 3) | (b >> 6);
          default: begin
            top = (r > g) ? r : g;
            if (b > top) top = b;
            idx = {2'd0, top[7:2]};
          end
        endcase
      end
      res.byte_low = idx + c.palette_start;
    end else if (c.pixel_format == FMT_RGB15) begin
      res.byte_count = CNT_TWO;
      res.byte_mid = ((r >> 1) & 8'h7C) | (g >> 6);
      res.byte_low = ((g << 2) & 8'hE0) | (b >> 3);
    end else if (c.pixel_format == FMT_RGB16) begin
      res.byte_count = CNT_TWO;
      res.byte_mid = (r & 8'hF8) | (g >> 5);
      res.byte_low = ((g << 3) & 8'hE0) | (b >> 3);
    end else begin
      res.byte_count = CNT_THREE;
      res.byte_high = r;
      res.byte_mid = g;
      res.byte_low = b;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    pix_out_t want;
    if (!rst_ni) begin
      regs.pixel_format = FMT_PAL8;
      regs.palette_kind = PAL_884;
      regs.palette_start = 8'd0;
      regs.dither_enable = 1'b0;
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_bytes.push_back(quantize_pixel(in_data_i, regs));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected pixel lo %h mid %h hi %h cnt %0d", $realtime,
                     out_data_i.byte_low, out_data_i.byte_mid, out_data_i.byte_high,
                     out_data_i.byte_count);
          end
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_i.byte_low !== want.byte_low || out_data_i.byte_mid !== want.byte_mid ||
              out_data_i.byte_high !== want.byte_high ||
              out_data_i.byte_count !== want.byte_count) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: pixel mismatch, expected lo %h mid %h hi %h cnt %0d, got lo %h mid %h hi %h cnt %0d",
                       $realtime, want.byte_low, want.byte_mid, want.byte_high,
                       want.byte_count, out_data_i.byte_low, out_data_i.byte_mid,
                       out_data_i.byte_high, out_data_i.byte_count);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PIXEL_FORMAT:  regs.pixel_format = cfg_wdata_i[2:0];
          CFG_PALETTE_KIND:  regs.palette_kind = cfg_wdata_i[1:0];
          CFG_PALETTE_START: regs.palette_start = cfg_wdata_i;
          CFG_DITHER_ENABLE: regs.dither_enable = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    fail_count_o <= errors;
    pending_o <= expected_bytes.size();
  end

endmodule

/* sim/pixel_color_quantizer_test.sv */
// Testbench top for the pixel color quantizer: drives pixels and register
// writes under varying idle and stall patterns and gives the verdict.
// Depends on pcq_pkg, pixel_color_quantizer and pixel_quant_checker.
`timescale 1ns / 1ps

module pixel_color_quantizer_test;
  import pcq_pkg::*;

  // format codes above 24-bit, which the block treats as 24-bit
  localparam logic [2:0] FMT_RSV5 = 3'd5;
  localparam logic [2:0] FMT_RSV6 = 3'd6;
  localparam logic [2:0] FMT_RSV7 = 3'd7;

  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int RAND_PHASES = 18;
  localparam int PHASE_PIXELS = 72;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pix_out_t out_data;
  int fail_count;
  int pending;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  pcq_cfg_t cur_cfg;

  pixel_color_quantizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pixel_quant_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic pix_in_t pix(input int r, input int g, input int b,
                                  input int x, input int y);
    pix_in_t p;
    p.red = 16'(r);
    p.green = 16'(g);
    p.blue = 16'(b);
    p.x_low = 3'(x);
    p.y_low = 3'(y);
    return p;
  endfunction

  function automatic pcq_cfg_t cfg_of(input logic [2:0] fmt, input logic [1:0] kind,
                                      input logic [7:0] start, input logic dith);
    pcq_cfg_t c;
    c.pixel_format = fmt;
    c.palette_kind = kind;
    c.palette_start = start;
    c.dither_enable = dith;
    return c;
  endfunction

  // mostly in-range intensities, some extremes and some full-range noise
  function automatic logic [15:0] rand_level();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'($urandom());
      1: begin
        case ($urandom_range(0, 6))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          3: v = 16'h1000;
          4: v = 16'h0FFF;
          5: v = 16'h1001;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom_range(0, 4608)) - 16'd256;
    endcase
    return v;
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      1: begin sender_idle_pct = 76; stall_pct = 0; end
      2: begin sender_idle_pct = 0; stall_pct = 76; end
      3: begin sender_idle_pct = 19; stall_pct = 19; end
      default: begin sender_idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input pcq_cfg_t c);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_PIXEL_FORMAT;
    cfg_wdata <= {5'd0, c.pixel_format};
    @(posedge clk_i);
    cfg_idx <= CFG_PALETTE_KIND;
    cfg_wdata <= {6'd0, c.palette_kind};
    @(posedge clk_i);
    cfg_idx <= CFG_PALETTE_START;
    cfg_wdata <= c.palette_start;
    @(posedge clk_i);
    cfg_idx <= CFG_DITHER_ENABLE;
    cfg_wdata <= {7'd0, c.dither_enable};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_pixel(input pix_in_t p);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic send_with(input pcq_cfg_t c, input pix_in_t p);
    if (c != cur_cfg) apply_config(c);
    send_pixel(p);
  endtask

  initial begin : stimulus
    pcq_cfg_t c;
    logic [2:0] fmt_list [RAND_PHASES];
    int mode;

    cur_cfg = cfg_of(FMT_PAL8, PAL_884, 8'd0, 1'b0);
    fmt_list = '{FMT_EGA4, FMT_PAL8, FMT_PAL8, FMT_PAL8, FMT_PAL8, FMT_RGB15,
                 FMT_RGB16, FMT_RGB24, FMT_RSV5, FMT_RSV6, FMT_RSV7, FMT_PAL8,
                 FMT_EGA4, FMT_RGB15, FMT_RGB16, FMT_RGB24, FMT_PAL8, FMT_PAL8};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings first, then each format and palette
    set_idling(0);
    send_with(cfg_of(FMT_PAL8, PAL_884, 8'd0, 1'b0), pix(0, 0, 0, 0, 0));
    send_with(cfg_of(FMT_PAL8, PAL_884, 8'd0, 1'b0), pix(4096, 4096, 4096, 7, 7));
    send_with(cfg_of(FMT_PAL8, PAL_884, 8'd0, 1'b0), pix(32767, -32768, 4095, 0, 7));
    send_with(cfg_of(FMT_PAL8, PAL_884, 8'd0, 1'b0), pix(-1, 1, 2048, 7, 0));
    c = cfg_of(FMT_EGA4, PAL_GREY, 8'd0, 1'b0);
    send_with(c, pix(4096, 0, 0, 0, 0));
    send_with(c, pix(0, 4096, 0, 0, 0));
    send_with(c, pix(0, 0, 4096, 0, 0));
    send_with(c, pix(4096, 4096, 0, 0, 0));
    send_with(c, pix(2048, 2048, 2048, 0, 0));
    send_with(c, pix(1024, 512, 256, 0, 0));
    // EGA packing inside the 8-bit format, offset wrapping past 255
    c = cfg_of(FMT_PAL8, PAL_EGA, 8'd255, 1'b1);
    send_with(c, pix(4096, 4096, 4096, 7, 7));
    send_with(c, pix(0, 0, 0, 0, 0));
    send_with(c, pix(-32768, -32768, -32768, 3, 4));
    c = cfg_of(FMT_PAL8, PAL_666, 8'd200, 1'b0);
    send_with(c, pix(4096, 2048, 1024, 0, 0));
    send_with(c, pix(32767, 0, -32768, 0, 0));
    send_with(cfg_of(FMT_PAL8, PAL_GREY, 8'd17, 1'b1), pix(1000, 3000, 2000, 3, 5));
    send_with(cfg_of(FMT_RGB15, PAL_884, 8'd0, 1'b1), pix(4096, 2048, 0, 7, 0));
    // 16-bit green split across both bytes
    c = cfg_of(FMT_RGB16, PAL_884, 8'd0, 1'b0);
    send_with(c, pix(0, 4096, 0, 0, 0));
    send_with(c, pix(4095, 1234, 4096, 0, 0));
    send_with(cfg_of(FMT_RSV7, PAL_666, 8'd9, 1'b1), pix(4096, 0, -1, 0, 7));
    send_with(cfg_of(FMT_RSV5, PAL_666, 8'd9, 1'b0), pix(2048, 100, 3000, 2, 6));
    send_with(cfg_of(FMT_RSV6, PAL_666, 8'd9, 1'b1), pix(10, 20, 30, 5, 5));
    send_with(cfg_of(FMT_RGB24, PAL_666, 8'd9, 1'b1), pix(32767, 32767, 32767, 7, 7));

    // random phases, each with its own settings and idling pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      c.pixel_format = fmt_list[ph];
      c.palette_kind = 2'(ph);
      case (ph % 3)
        0: c.palette_start = 8'd0;
        1: c.palette_start = 8'd255;
        default: c.palette_start = 8'($urandom());
      endcase
      c.dither_enable = (ph < 2) ? 1'(ph) : 1'($urandom_range(0, 1));
      mode = ph % 4;
      apply_config(c);
      set_idling(mode);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // long output hold-off while pixels keep coming, to back up the pipe
        if (mode == 0 && n == 10 && ph % 8 == 0) hold_asked++;
        send_pixel(pix(int'($signed(rand_level())), int'($signed(rand_level())),
                       int'($signed(rand_level())), $urandom_range(0, 7),
                       $urandom_range(0, 7)));
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
